// File: src/spc_pkg.sv
// spc_pkg: widths, payload types and register codes for the segment plane clipper
// used by spc_div_pipe and segment_plane_clipper; no dependencies
`timescale 1ns / 1ps

package spc_pkg;

    localparam int CoordWidth    = 24;
    localparam int NormalWidth   = 16;
    localparam int NormalFrac    = 14;
    localparam int OffsetWidth   = 24;
    localparam int CfgDataWidth  = 24;
    localparam int CfgIndexWidth = 3;
    localparam int FracWidth     = 16;

    // wide enough for |d| of either endpoint and for the sum of two magnitudes
    localparam int ProdWidth = CoordWidth + NormalWidth;
    localparam int DistWidth = ((ProdWidth + 1 > OffsetWidth + NormalFrac) ?
                                (ProdWidth + 1) : (OffsetWidth + NormalFrac)) + 2;

    localparam int LerpWidth = CoordWidth + FracWidth + 2;

    localparam logic [CfgIndexWidth-1:0] RegNormalX     = CfgIndexWidth'(0);
    localparam logic [CfgIndexWidth-1:0] RegNormalY     = CfgIndexWidth'(1);
    localparam logic [CfgIndexWidth-1:0] RegNormalZ     = CfgIndexWidth'(2);
    localparam logic [CfgIndexWidth-1:0] RegPlaneOffset = CfgIndexWidth'(3);

    typedef logic signed [CoordWidth-1:0] coord_t;
    typedef logic signed [DistWidth-1:0]  dist_t;
    typedef logic [DistWidth-1:0]         mag_t;
    typedef logic [FracWidth-1:0]         frac_t;

    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t start_z;
        coord_t end_x;
        coord_t end_y;
        coord_t end_z;
    } seg_t;

    typedef struct packed {
        logic clip;
        logic keep;
        logic start_pos;
    } clip_ctl_t;

endpackage

// File: src/spc_div_pipe.sv
// spc_div_pipe: pipelined restoring divider, one quotient bit per stage
// forms floor(a1 * 2^16 / (a1 + a2)) and carries the segment alongside; uses spc_pkg
`timescale 1ns / 1ps

module spc_div_pipe (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  spc_pkg::mag_t         in_rem,
    input  spc_pkg::mag_t         in_div,
    input  spc_pkg::seg_t         in_seg,
    input  spc_pkg::clip_ctl_t    in_ctl,
    output logic                  out_valid,
    input  logic                  out_ready,
    output spc_pkg::frac_t        out_quo,
    output spc_pkg::seg_t         out_seg,
    output spc_pkg::clip_ctl_t    out_ctl
);

    localparam int Steps = spc_pkg::FracWidth;

    logic [Steps-1:0]     valid_reg;
    logic [Steps:0]       ld;
    spc_pkg::mag_t        rem_reg [Steps];
    spc_pkg::mag_t        div_reg [Steps];
    spc_pkg::frac_t       quo_reg [Steps];
    spc_pkg::seg_t        seg_reg [Steps];
    spc_pkg::clip_ctl_t   ctl_reg [Steps];

    assign ld[Steps] = out_ready;

    for (genvar k = 0; k < Steps; k++) begin : g_step
        logic                        v_in;
        spc_pkg::mag_t               rem_in;
        spc_pkg::mag_t               div_in;
        spc_pkg::frac_t              quo_in;
        spc_pkg::seg_t               seg_in;
        spc_pkg::clip_ctl_t          ctl_in;
        logic [spc_pkg::DistWidth:0] shifted;
        logic [spc_pkg::DistWidth:0] diff;
        logic                        fits;

        if (k == 0) begin : g_first
            assign v_in   = in_valid;
            assign rem_in = in_rem;
            assign div_in = in_div;
            assign quo_in = '0;
            assign seg_in = in_seg;
            assign ctl_in = in_ctl;
        end else begin : g_rest
            assign v_in   = valid_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign div_in = div_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign seg_in = seg_reg[k-1];
            assign ctl_in = ctl_reg[k-1];
        end

        assign shifted = {rem_in, 1'b0};
        assign diff    = shifted - {1'b0, div_in};
        assign fits    = (shifted >= {1'b0, div_in});
        assign ld[k]   = !valid_reg[k] || ld[k+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (ld[k]) begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ld[k] && v_in) begin
                rem_reg[k] <= fits ? diff[spc_pkg::DistWidth-1:0]
                                   : shifted[spc_pkg::DistWidth-1:0];
                div_reg[k] <= div_in;
                quo_reg[k] <= {quo_in[spc_pkg::FracWidth-2:0], fits};
                seg_reg[k] <= seg_in;
                ctl_reg[k] <= ctl_in;
            end
        end
    end

    assign in_ready  = ld[0];
    assign out_valid = valid_reg[Steps-1];
    assign out_quo   = quo_reg[Steps-1];
    assign out_seg   = seg_reg[Steps-1];
    assign out_ctl   = ctl_reg[Steps-1];

    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && out_ctl.clip |-> rem_reg[Steps-1] < div_reg[Steps-1])
        else $error("divider remainder not below divisor");

    a_first_stage_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> valid_reg[0])
        else $error("accepted beat missing from first divider stage");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> valid_reg == '0)
        else $error("divider stages not empty after reset");

endmodule

// File: src/segment_plane_clipper.sv
// segment_plane_clipper: clips a 3d segment against a configured plane, fixed point
// uses spc_pkg and spc_div_pipe
//
//   port group  dir  handshake           payload
//   s_*         in   s_valid / s_ready   start_x/y/z, end_x/y/z
//   m_*         out  m_valid / m_ready   out_start_x/y/z, out_end_x/y/z, keep
//   cfg_*       in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one beat per cycle sustained while m_ready is high; a result leaves once its beat has passed every stage
// stages: products, distances, classify, 16 divider stages, lerp multiply, output register
// each stage holds its beat only while the one after it is full and cannot move on, so bubbles close up under stall
// aresetn clears all valid bits; cfg_ready is always high
`timescale 1ns / 1ps

module segment_plane_clipper (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [spc_pkg::CfgIndexWidth-1:0]  cfg_index,
    input  logic [spc_pkg::CfgDataWidth-1:0]   cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [spc_pkg::CoordWidth-1:0] s_start_x,
    input  logic signed [spc_pkg::CoordWidth-1:0] s_start_y,
    input  logic signed [spc_pkg::CoordWidth-1:0] s_start_z,
    input  logic signed [spc_pkg::CoordWidth-1:0] s_end_x,
    input  logic signed [spc_pkg::CoordWidth-1:0] s_end_y,
    input  logic signed [spc_pkg::CoordWidth-1:0] s_end_z,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [spc_pkg::CoordWidth-1:0] m_out_start_x,
    output logic signed [spc_pkg::CoordWidth-1:0] m_out_start_y,
    output logic signed [spc_pkg::CoordWidth-1:0] m_out_start_z,
    output logic signed [spc_pkg::CoordWidth-1:0] m_out_end_x,
    output logic signed [spc_pkg::CoordWidth-1:0] m_out_end_y,
    output logic signed [spc_pkg::CoordWidth-1:0] m_out_end_z,
    output logic                               m_keep
);

    localparam int W  = spc_pkg::CoordWidth;
    localparam int DW = spc_pkg::DistWidth;
    localparam int PW = spc_pkg::ProdWidth;
    localparam int LW = spc_pkg::LerpWidth;
    localparam int FW = spc_pkg::FracWidth;

    // plane registers
    logic signed [spc_pkg::NormalWidth-1:0] nx_reg, ny_reg, nz_reg;
    logic signed [spc_pkg::OffsetWidth-1:0] offset_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nx_reg     <= '0;
            ny_reg     <= '0;
            nz_reg     <= spc_pkg::NormalWidth'(1 << spc_pkg::NormalFrac);
            offset_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                spc_pkg::RegNormalX:     nx_reg     <= cfg_data[spc_pkg::NormalWidth-1:0];
                spc_pkg::RegNormalY:     ny_reg     <= cfg_data[spc_pkg::NormalWidth-1:0];
                spc_pkg::RegNormalZ:     nz_reg     <= cfg_data[spc_pkg::NormalWidth-1:0];
                spc_pkg::RegPlaneOffset: offset_reg <= cfg_data[spc_pkg::OffsetWidth-1:0];
                default: ;
            endcase
        end
    end

    // load enables, back to front
    logic ld_a, ld_b, ld_c, ld_d, ld_e;
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, m_valid_reg;
    logic div_in_ready, div_out_valid;

    assign ld_e    = !m_valid_reg || m_ready;
    assign ld_d    = !d_valid_reg || ld_e;
    assign ld_c    = !c_valid_reg || div_in_ready;
    assign ld_b    = !b_valid_reg || ld_c;
    assign ld_a    = !a_valid_reg || ld_b;
    assign s_ready = ld_a;
    assign m_valid = m_valid_reg;

    // stage a: coordinate times normal
    spc_pkg::seg_t           s_seg;
    spc_pkg::seg_t           a_seg_reg;
    logic signed [PW-1:0]    a_prod_reg [6];

    assign s_seg = '{start_x: s_start_x, start_y: s_start_y, start_z: s_start_z,
                     end_x: s_end_x, end_y: s_end_y, end_z: s_end_z};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (ld_a) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_a && s_valid) begin
            a_seg_reg     <= s_seg;
            a_prod_reg[0] <= s_start_x * nx_reg;
            a_prod_reg[1] <= s_start_y * ny_reg;
            a_prod_reg[2] <= s_start_z * nz_reg;
            a_prod_reg[3] <= s_end_x * nx_reg;
            a_prod_reg[4] <= s_end_y * ny_reg;
            a_prod_reg[5] <= s_end_z * nz_reg;
        end
    end

    // stage b: signed distances
    spc_pkg::dist_t b_d1_reg, b_d2_reg;
    spc_pkg::seg_t  b_seg_reg;
    spc_pkg::dist_t off_term;
    spc_pkg::dist_t d1_next, d2_next;

    assign off_term = spc_pkg::dist_t'(offset_reg) <<< spc_pkg::NormalFrac;
    assign d1_next  = spc_pkg::dist_t'(a_prod_reg[0]) + spc_pkg::dist_t'(a_prod_reg[1])
                    + spc_pkg::dist_t'(a_prod_reg[2]) - off_term;
    assign d2_next  = spc_pkg::dist_t'(a_prod_reg[3]) + spc_pkg::dist_t'(a_prod_reg[4])
                    + spc_pkg::dist_t'(a_prod_reg[5]) - off_term;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (ld_b) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_b && a_valid_reg) begin
            b_d1_reg  <= d1_next;
            b_d2_reg  <= d2_next;
            b_seg_reg <= a_seg_reg;
        end
    end

    // stage c: classify, magnitudes and divisor
    logic               d1_neg, d2_neg, d1_zero, d2_zero, both_front, both_back;
    spc_pkg::mag_t      a1, a2;
    spc_pkg::clip_ctl_t ctl_next;
    spc_pkg::clip_ctl_t c_ctl_reg;
    spc_pkg::mag_t      c_a1_reg, c_div_reg;
    spc_pkg::seg_t      c_seg_reg;

    assign d1_neg     = b_d1_reg[DW-1];
    assign d2_neg     = b_d2_reg[DW-1];
    assign d1_zero    = (b_d1_reg == '0);
    assign d2_zero    = (b_d2_reg == '0);
    assign both_front = !d1_neg && !d2_neg;
    assign both_back  = (d1_neg || d1_zero) && (d2_neg || d2_zero);
    assign a1         = d1_neg ? spc_pkg::mag_t'(-b_d1_reg) : spc_pkg::mag_t'(b_d1_reg);
    assign a2         = d2_neg ? spc_pkg::mag_t'(-b_d2_reg) : spc_pkg::mag_t'(b_d2_reg);

    assign ctl_next.clip      = !both_front && !both_back;
    assign ctl_next.keep      = !both_front;
    assign ctl_next.start_pos = !d1_neg && !d1_zero;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (ld_c) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_c && b_valid_reg) begin
            c_ctl_reg <= ctl_next;
            c_a1_reg  <= a1;
            c_div_reg <= a1 + a2;
            c_seg_reg <= b_seg_reg;
        end
    end

    // divider stages
    spc_pkg::frac_t     div_quo;
    spc_pkg::seg_t      div_seg;
    spc_pkg::clip_ctl_t div_ctl;

    spc_div_pipe u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (c_valid_reg),
        .in_ready  (div_in_ready),
        .in_rem    (c_a1_reg),
        .in_div    (c_div_reg),
        .in_seg    (c_seg_reg),
        .in_ctl    (c_ctl_reg),
        .out_valid (div_out_valid),
        .out_ready (ld_d),
        .out_quo   (div_quo),
        .out_seg   (div_seg),
        .out_ctl   (div_ctl)
    );

    // stage d: dt times (end - start)
    logic signed [FW:0]   dt_s;
    logic signed [W:0]    dx, dy, dz;
    logic signed [LW-1:0] d_prod_reg [3];
    spc_pkg::seg_t        d_seg_reg;
    spc_pkg::clip_ctl_t   d_ctl_reg;

    assign dt_s = $signed({1'b0, div_quo});
    assign dx   = $signed({div_seg.end_x[W-1], div_seg.end_x})
                - $signed({div_seg.start_x[W-1], div_seg.start_x});
    assign dy   = $signed({div_seg.end_y[W-1], div_seg.end_y})
                - $signed({div_seg.start_y[W-1], div_seg.start_y});
    assign dz   = $signed({div_seg.end_z[W-1], div_seg.end_z})
                - $signed({div_seg.start_z[W-1], div_seg.start_z});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (ld_d) begin
            d_valid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_d && div_out_valid) begin
            d_prod_reg[0] <= dt_s * dx;
            d_prod_reg[1] <= dt_s * dy;
            d_prod_reg[2] <= dt_s * dz;
            d_seg_reg     <= div_seg;
            d_ctl_reg     <= div_ctl;
        end
    end

    // stage e: floor of the step, add to start, pick endpoint
    spc_pkg::coord_t cx, cy, cz;
    spc_pkg::seg_t   out_next;

    assign cx = d_seg_reg.start_x + d_prod_reg[0][FW +: W];
    assign cy = d_seg_reg.start_y + d_prod_reg[1][FW +: W];
    assign cz = d_seg_reg.start_z + d_prod_reg[2][FW +: W];

    always_comb begin
        out_next = d_seg_reg;
        if (d_ctl_reg.clip) begin
            if (d_ctl_reg.start_pos) begin
                out_next.start_x = cx;
                out_next.start_y = cy;
                out_next.start_z = cz;
            end else begin
                out_next.end_x = cx;
                out_next.end_y = cy;
                out_next.end_z = cz;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ld_e) begin
            m_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_e && d_valid_reg) begin
            m_out_start_x <= out_next.start_x;
            m_out_start_y <= out_next.start_y;
            m_out_start_z <= out_next.start_z;
            m_out_end_x   <= out_next.end_x;
            m_out_end_y   <= out_next.end_y;
            m_out_end_z   <= out_next.end_z;
            m_keep        <= d_ctl_reg.keep;
        end
    end

    a_clip_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        c_valid_reg && c_ctl_reg.clip |-> (c_a1_reg != '0) && (c_a1_reg < c_div_reg))
        else $error("clip beat with dividend not inside divisor");

    a_front_no_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        c_valid_reg && !c_ctl_reg.keep |-> !c_ctl_reg.clip)
        else $error("segment in front marked for clipping");

    a_reset_out_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg)
        else $error("result beat valid after reset");

endmodule
